// ----- rtl/mc3b_pkg.sv -----
// ============================================================================
// mc3b_pkg
// Shared types and constants of the 3D Morton encoder with running bounds.
// ============================================================================
`default_nettype none

package mc3b_pkg;

    localparam int GRID_BITS_DEF  = 10;
    localparam int COORD_BITS_DEF = 32;

    localparam int CODE_W         = 30;
    localparam int CELLS_PER_AXIS = CODE_W / 3;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic sat;
    } t_lane_stat;

endpackage

`default_nettype wire

// ----- rtl/mc3b_lane.sv -----
// ============================================================================
// mc3b_lane
// One axis: range check against the bounds, then a restoring divider that
// produces one grid bit per cycle.
// ============================================================================
`default_nettype none

module mc3b_lane #(
    parameter int GRID_BITS  = 10,
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_coord,
    input  logic signed [COORD_BITS-1:0] i_lo,
    input  logic signed [COORD_BITS-1:0] i_hi,
    output logic        [GRID_BITS-1:0]  o_cell,
    output mc3b_pkg::t_lane_stat         o_stat
);
    import mc3b_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int CNT_W = $clog2(GRID_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic signed [CW:0]  r_num, n_num;
    logic signed [CW:0]  r_den, n_den;
    logic [CW-1:0]       r_rem, n_rem;
    logic [GRID_BITS-1:0] r_q, n_q;
    logic                r_sat, n_sat;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic [CW:0]         w_rem2;
    logic [CW:0]         w_dvs;
    logic [CW:0]         w_diff;
    logic                w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_dvs  = {1'b0, r_den[CW-1:0]};
    assign w_diff = w_rem2 - w_dvs;
    assign w_ge   = (w_rem2 >= w_dvs);

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_q     = r_q;
        n_sat   = r_sat;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_num   = $signed({i_coord[CW-1], i_coord}) - $signed({i_lo[CW-1], i_lo});
                    n_den   = $signed({i_hi[CW-1], i_hi}) - $signed({i_lo[CW-1], i_lo});
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                n_rem = r_num[CW-1:0];
                if (r_den[CW] || (r_den == '0)) begin
                    n_q     = '0;
                    n_sat   = 1'b0;
                    n_state = S_IDLE;
                end else if (r_num[CW]) begin
                    n_q     = '0;
                    n_sat   = 1'b1;
                    n_state = S_IDLE;
                end else if (r_num >= r_den) begin
                    n_q     = '1;
                    n_sat   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_q     = '0;
                    n_sat   = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[CW-1:0] : w_rem2[CW-1:0];
                n_q   = GRID_BITS'({r_q, w_ge});
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(GRID_BITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_sat <= n_sat;
        r_cnt <= n_cnt;
    end

    assign o_cell      = r_q;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.sat  = r_sat;

endmodule

`default_nettype wire

// ----- rtl/mc3b_merge.sv -----
// ============================================================================
// mc3b_merge
// Interleave the three axis cells into the Morton code and hold the result
// word in the output register.
// ============================================================================
`default_nettype none

module mc3b_merge #(
    parameter int GRID_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [GRID_BITS-1:0]         i_cell_x,
    input  logic [GRID_BITS-1:0]         i_cell_y,
    input  logic [GRID_BITS-1:0]         i_cell_z,
    input  logic                         i_sat,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [mc3b_pkg::CODE_W-1:0]  o_morton_code,
    output logic                         o_clamped
);
    import mc3b_pkg::*;

    logic [CELLS_PER_AXIS-1:0] w_gx, w_gy, w_gz;
    logic [CODE_W-1:0]         w_code;
    logic                      r_valid, n_valid;
    logic [CODE_W-1:0]         r_code;
    logic                      r_clamped;

    assign w_gx = CELLS_PER_AXIS'(i_cell_x);
    assign w_gy = CELLS_PER_AXIS'(i_cell_y);
    assign w_gz = CELLS_PER_AXIS'(i_cell_z);

    for (genvar gi = 0; gi < CELLS_PER_AXIS; gi++) begin : g_ilv
        assign w_code[3*gi]     = w_gx[gi];
        assign w_code[3*gi + 1] = w_gy[gi];
        assign w_code[3*gi + 2] = w_gz[gi];
    end

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_code    <= w_code;
            r_clamped <= i_sat;
        end
    end

    assign o_valid       = r_valid;
    assign o_morton_code = r_code;
    assign o_clamped     = r_clamped;

endmodule

`default_nettype wire

// ----- rtl/morton_code_3d_with_bounds_top.sv -----
// ============================================================================
// morton_code_3d_with_bounds_top
// Two-pass 3D Morton encoder: running per-axis bounds, three divider lanes
// and an interleaving output stage.
// ============================================================================
// Clear and accumulate words give no result. An encode word passes through
// these steps before its result word is loaded into the output register:
// p-min and max-min are formed, the range check is made, then one quotient
// bit per cycle comes out of each of the three per-axis restoring dividers,
// which run side by side, for a coordinate inside its bounds. Once the
// dividers are done, the result moves into the output register as soon as
// that register is empty or being read, and only then is the next input word
// taken; the result may still wait in the output register meanwhile.
`default_nettype none

module morton_code_3d_with_bounds_top #(
    parameter int GRID_BITS  = mc3b_pkg::GRID_BITS_DEF,
    parameter int COORD_BITS = mc3b_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_command,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mc3b_pkg::CODE_W-1:0]  o_morton_code,
    output logic                         o_clamped
);
    import mc3b_pkg::*;

    localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic signed [COORD_BITS-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [COORD_BITS-1:0] r_max_x, r_max_y, r_max_z;

    logic                 w_accept;
    logic                 w_start;
    logic                 w_lanes_done;
    logic                 w_load;
    logic                 w_out_valid;
    t_cmd                 w_cmd;
    t_lane_stat           w_stat_x, w_stat_y, w_stat_z;
    logic [GRID_BITS-1:0] w_cell_x, w_cell_y, w_cell_z;

    assign o_ready      = (r_state == S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_cmd        = t_cmd'(i_command);
    assign w_start      = w_accept && (w_cmd == CMD_ENCODE);
    assign w_lanes_done = !w_stat_x.busy && !w_stat_y.busy && !w_stat_z.busy;
    assign w_load       = (r_state == S_WORK) && w_lanes_done && (!w_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min_x <= MAXV;
            r_min_y <= MAXV;
            r_min_z <= MAXV;
            r_max_x <= MINV;
            r_max_y <= MINV;
            r_max_z <= MINV;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                case (w_cmd)
                    CMD_CLEAR: begin
                        r_min_x <= MAXV;
                        r_min_y <= MAXV;
                        r_min_z <= MAXV;
                        r_max_x <= MINV;
                        r_max_y <= MINV;
                        r_max_z <= MINV;
                    end
                    CMD_ACCUM: begin
                        if (i_coord_x < r_min_x) r_min_x <= i_coord_x;
                        if (i_coord_y < r_min_y) r_min_y <= i_coord_y;
                        if (i_coord_z < r_min_z) r_min_z <= i_coord_z;
                        if (i_coord_x > r_max_x) r_max_x <= i_coord_x;
                        if (i_coord_y > r_max_y) r_max_y <= i_coord_y;
                        if (i_coord_z > r_max_z) r_max_z <= i_coord_z;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    mc3b_lane #(
        .GRID_BITS (GRID_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_lane_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_coord(i_coord_x),
        .i_lo   (r_min_x),
        .i_hi   (r_max_x),
        .o_cell (w_cell_x),
        .o_stat (w_stat_x)
    );

    mc3b_lane #(
        .GRID_BITS (GRID_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_lane_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_coord(i_coord_y),
        .i_lo   (r_min_y),
        .i_hi   (r_max_y),
        .o_cell (w_cell_y),
        .o_stat (w_stat_y)
    );

    mc3b_lane #(
        .GRID_BITS (GRID_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_lane_z (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_coord(i_coord_z),
        .i_lo   (r_min_z),
        .i_hi   (r_max_z),
        .o_cell (w_cell_z),
        .o_stat (w_stat_z)
    );

    mc3b_merge #(
        .GRID_BITS(GRID_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_cell_x     (w_cell_x),
        .i_cell_y     (w_cell_y),
        .i_cell_z     (w_cell_z),
        .i_sat        (w_stat_x.sat || w_stat_y.sat || w_stat_z.sat),
        .i_ready      (i_ready),
        .o_valid      (w_out_valid),
        .o_morton_code(o_morton_code),
        .o_clamped    (o_clamped)
    );

    assign o_valid = w_out_valid;

endmodule

`default_nettype wire
